>>> hdl/adm_pkg.sv
// Package for the adjacency-matrix depth-first search block.
// Holds sizes, field types, result codes and memory request structs.
// No dependencies; every other file imports it.
`default_nettype none

package adm_pkg;

	// Sizes
	localparam int MAX_VERTICES = 16;
	localparam int STACK_DEPTH  = 256;
	localparam int VERT_W       = 5;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int SADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W         = SADDR_W + 1;
	localparam int CFG_W        = 5;
	localparam int PADDR_W      = 3;
	localparam int PDATA_W      = 32;

	// Configuration
	localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd8;
	localparam logic [CFG_W-1:0] VCOUNT_MIN   = 5'd2;
	localparam logic             REG_VERTEX_COUNT = 1'b0;

	// Operation codes
	localparam logic OP_ADD_EDGE = 1'b0;
	localparam logic OP_SEARCH   = 1'b1;

	// Result status codes
	localparam logic [1:0] STS_VISITED  = 2'd0;
	localparam logic [1:0] STS_GOAL     = 2'd1;
	localparam logic [1:0] STS_REJECTED = 2'd2;
	localparam logic [1:0] STS_MISSED   = 2'd3;

	typedef logic [VERT_W-1:0]       vertex_t;
	typedef logic [VIDX_W-1:0]       vidx_t;
	typedef logic [MAX_VERTICES-1:0] row_t;
	typedef logic [SADDR_W-1:0]      saddr_t;
	typedef logic [SP_W-1:0]         sp_t;

	// Adjacency row memory request
	typedef struct packed {
		logic  rd_en;
		vidx_t rd_idx;
		logic  wr_en;
		vidx_t wr_idx;
		row_t  wr_row;
	} adj_req_t;

	// Pending-vertex stack request
	typedef struct packed {
		logic    rd_en;
		saddr_t  rd_addr;
		logic    wr_en;
		saddr_t  wr_addr;
		vertex_t wr_data;
	} stk_req_t;

	// Vertex number (from 1) to row or bit index (from 0)
	function automatic vidx_t to_idx(input vertex_t v);
		vertex_t d;
		d = v - vertex_t'(1);
		return d[VIDX_W-1:0];
	endfunction

	// One-hot bit for a vertex number
	function automatic row_t bit_of(input vertex_t v);
		return row_t'(1) << to_idx(v);
	endfunction

endpackage

`default_nettype wire

>>> hdl/adjacency_matrix_dfs.sv
// Top level of the adjacency-matrix depth-first search block.
// Holds the APB register, the walk sequencer and the result register.
// Depends on adm_pkg, adm_adj_mem and adm_stack_mem.
//
//  Channel  | Signals                                     | Handshake
//  ---------+---------------------------------------------+-------------------------
//  input    | operation, vertex_a, vertex_b               | in_valid / in_ready
//  result   | vertex, status, last                        | out_valid / out_ready
//  config   | psel penable pwrite paddr pwdata prdata     | APB, pready tied high
//
// An edge add makes two read-modify-write passes on the row memory.
// A search passes each visited vertex through the visit, load and scan states, pushing
// its unvisited neighbors up to the stack depth, and each popped entry through the pop and check states.
// A new item is taken only when the sequencer is idle; a finished result may
// still wait in the result register. A full result register stalls the walk.
// Reset clears the matrix through per-row valid flags; no clearing pass.
`default_nettype none

module adjacency_matrix_dfs
	import adm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input items
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               operation,
	input  wire logic [VERT_W-1:0]  vertex_a,
	input  wire logic [VERT_W-1:0]  vertex_b,
	// result items
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [VERT_W-1:0]       vertex,
	output logic [1:0]              status,
	output logic                    last,
	// configuration
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam int NMASK_W = MAX_VERTICES + 1;

	// Sequencer states
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_E_RDA   = 4'd1;
	localparam logic [3:0] S_E_WRA   = 4'd2;
	localparam logic [3:0] S_E_RDB   = 4'd3;
	localparam logic [3:0] S_E_WRB   = 4'd4;
	localparam logic [3:0] S_REJECT  = 4'd5;
	localparam logic [3:0] S_VISIT   = 4'd6;
	localparam logic [3:0] S_LOAD    = 4'd7;
	localparam logic [3:0] S_SCAN    = 4'd8;
	localparam logic [3:0] S_POP     = 4'd9;
	localparam logic [3:0] S_POPCHK  = 4'd10;
	localparam logic [3:0] S_MISS    = 4'd11;

	logic [3:0]       state_q;
	logic [CFG_W-1:0] vcount_q;
	vidx_t            edge_a_q;
	vidx_t            edge_b_q;
	vertex_t          cur_q;
	vertex_t          goal_q;
	row_t             visited_q;
	row_t             mask_q;
	sp_t              sp_q;

	logic             out_valid_q;
	vertex_t          vertex_q;
	logic [1:0]       status_q;
	logic             last_q;

	vertex_t            n_act;
	logic [NMASK_W-1:0] nmask_ext;
	row_t               nmask;
	logic               cfg_wr;
	logic               in_acc;
	logic               a_ok;
	logic               b_ok;
	logic               b_goal_ok;
	logic               out_free;
	logic               emit;
	vertex_t            emit_vertex;
	logic [1:0]         emit_status;
	logic               emit_last;
	vidx_t              low_idx;
	vertex_t            low_vertex;
	logic               sp_full;
	sp_t                sp_m1;
	vertex_t            pop_v;
	logic               pop_ok;
	row_t               adj_row;
	vertex_t            stk_rd;
	adj_req_t           adj_req;
	stk_req_t           stk_req;

	// Clamp the vertex count to the supported range
	always_comb begin
		if (vcount_q < VCOUNT_MIN) begin
			n_act = vertex_t'(VCOUNT_MIN);
		end else if (vcount_q > CFG_W'(MAX_VERTICES)) begin
			n_act = vertex_t'(MAX_VERTICES);
		end else begin
			n_act = vertex_t'(vcount_q);
		end
	end

	assign nmask_ext = (NMASK_W'(1) << n_act) - NMASK_W'(1);
	assign nmask     = nmask_ext[MAX_VERTICES-1:0];

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? PDATA_W'(vcount_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= VCOUNT_RESET;
		end else if (cfg_wr) begin
			vcount_q <= pwdata[CFG_W-1:0];
		end
	end

	// Input checks
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign a_ok      = (vertex_a != '0) && (vertex_a <= n_act);
	assign b_ok      = (vertex_b != '0) && (vertex_b <= n_act);
	assign b_goal_ok = (vertex_b <= n_act);

	// Lowest pending neighbor first, so the highest one pops first
	always_comb begin
		low_idx = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = VIDX_W'(i);
			end
		end
	end

	assign low_vertex = vertex_t'(low_idx) + vertex_t'(1);
	assign sp_full    = (sp_q == SP_W'(STACK_DEPTH));
	assign sp_m1      = sp_q - sp_t'(1);
	assign pop_v      = stk_rd;
	assign pop_ok     = (pop_v != '0) && (pop_v <= n_act) && !visited_q[to_idx(pop_v)];
	assign out_free   = !out_valid_q || out_ready;

	// Memory requests and result emission
	always_comb begin
		adj_req     = '0;
		stk_req     = '0;
		emit        = 1'b0;
		emit_vertex = '0;
		emit_status = STS_VISITED;
		emit_last   = 1'b0;
		unique case (state_q)
			S_E_RDA: begin
				adj_req.rd_en  = 1'b1;
				adj_req.rd_idx = edge_a_q;
			end
			S_E_WRA: begin
				adj_req.wr_en  = 1'b1;
				adj_req.wr_idx = edge_a_q;
				adj_req.wr_row = adj_row | (row_t'(1) << edge_b_q);
			end
			S_E_RDB: begin
				adj_req.rd_en  = 1'b1;
				adj_req.rd_idx = edge_b_q;
			end
			S_E_WRB: begin
				adj_req.wr_en  = 1'b1;
				adj_req.wr_idx = edge_b_q;
				adj_req.wr_row = adj_row | (row_t'(1) << edge_a_q);
			end
			S_VISIT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_vertex = cur_q;
					if (cur_q == goal_q) begin
						emit_status = STS_GOAL;
						emit_last   = 1'b1;
					end else begin
						adj_req.rd_en  = 1'b1;
						adj_req.rd_idx = to_idx(cur_q);
					end
				end
			end
			S_SCAN: begin
				if ((mask_q != '0) && !sp_full) begin
					stk_req.wr_en   = 1'b1;
					stk_req.wr_addr = sp_q[SADDR_W-1:0];
					stk_req.wr_data = low_vertex;
				end
			end
			S_POP: begin
				if (sp_q != '0) begin
					stk_req.rd_en   = 1'b1;
					stk_req.rd_addr = sp_m1[SADDR_W-1:0];
				end
			end
			S_MISS: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = STS_MISSED;
					emit_last   = 1'b1;
				end
			end
			S_REJECT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = STS_REJECTED;
					emit_last   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Walk sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			visited_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (operation == OP_ADD_EDGE) begin
							if (a_ok && b_ok) begin
								state_q <= S_E_RDA;
							end
						end else if (a_ok && b_goal_ok) begin
							visited_q <= '0;
							sp_q      <= '0;
							state_q   <= S_VISIT;
						end else begin
							state_q <= S_REJECT;
						end
					end
				end
				S_E_RDA:  state_q <= S_E_WRA;
				S_E_WRA:  state_q <= S_E_RDB;
				S_E_RDB:  state_q <= S_E_WRB;
				S_E_WRB:  state_q <= S_IDLE;
				S_VISIT: begin
					if (out_free) begin
						visited_q <= visited_q | bit_of(cur_q);
						state_q   <= (cur_q == goal_q) ? S_IDLE : S_LOAD;
					end
				end
				S_LOAD:   state_q <= S_SCAN;
				S_SCAN: begin
					if (mask_q == '0) begin
						state_q <= S_POP;
					end else if (!sp_full) begin
						sp_q <= sp_q + sp_t'(1);
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_MISS;
					end else begin
						sp_q    <= sp_m1;
						state_q <= S_POPCHK;
					end
				end
				S_POPCHK: state_q <= pop_ok ? S_VISIT : S_POP;
				S_MISS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_REJECT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Walk payload: edge endpoints, current vertex, goal, neighbor mask
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			edge_a_q <= to_idx(vertex_a);
			edge_b_q <= to_idx(vertex_b);
			cur_q    <= vertex_a;
			goal_q   <= vertex_b;
		end
		if (state_q == S_POPCHK && pop_ok) begin
			cur_q <= pop_v;
		end
		if (state_q == S_LOAD) begin
			mask_q <= adj_row & ~visited_q & nmask;
		end else if (state_q == S_SCAN && mask_q != '0) begin
			mask_q <= mask_q & ~(row_t'(1) << low_idx);
		end
	end

	// Result register: hold until taken, load on emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			vertex_q <= emit_vertex;
			status_q <= emit_status;
			last_q   <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign vertex    = vertex_q;
	assign status    = status_q;
	assign last      = last_q;

	adm_adj_mem u_adj_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (adj_req),
		.rd_row (adj_row)
	);

	adm_stack_mem u_stack_mem (
		.clk     (clk),
		.req     (stk_req),
		.rd_data (stk_rd)
	);

	// Reaching the goal ends the search
	a_goal_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_VISIT && out_free && cur_q == goal_q) |=> (state_q == S_IDLE))
		else $error("search did not end at the goal");

	// Stack pointer never passes the stack depth
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// The current vertex is marked before its neighbors are scanned
	a_load_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> visited_q[to_idx(cur_q)])
		else $error("current vertex not marked visited");

	// A result appears only from an emitting state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_VISIT || $past(state_q) == S_MISS
			|| $past(state_q) == S_REJECT))
		else $error("result loaded outside an emitting state");

endmodule

`default_nettype wire

>>> hdl/adm_adj_mem.sv
// Adjacency row memory: one row per vertex, registered read.
// Per-row valid flags make unwritten rows read as zero after reset.
// Depends on adm_pkg.
`default_nettype none

module adm_adj_mem
	import adm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire adj_req_t req,
	output row_t          rd_row
);

	row_t                    rows_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_vld_q;
	row_t                    rd_data_q;
	logic                    rd_vld_q;

	// Write the row array and register reads
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			rows_mem[req.wr_idx] <= req.wr_row;
		end
		if (req.rd_en) begin
			rd_data_q <= rows_mem[req.rd_idx];
		end
	end

	// Track written rows; latch validity of the row being read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (req.wr_en) begin
				row_vld_q[req.wr_idx] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= row_vld_q[req.rd_idx];
			end
		end
	end

	assign rd_row = rd_vld_q ? rd_data_q : '0;

	// Read and write never hit the same row in one cycle
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(req.rd_en && req.wr_en) |-> (req.rd_idx != req.wr_idx))
		else $error("adjacency row read and written in the same cycle");

endmodule

`default_nettype wire

>>> hdl/adm_stack_mem.sv
// Pending-vertex stack storage: single-port write, registered read.
// Contents are undefined until written; the stack pointer lives outside.
// Depends on adm_pkg.
`default_nettype none

module adm_stack_mem
	import adm_pkg::*;
(
	input  wire logic     clk,
	input  wire stk_req_t req,
	output vertex_t       rd_data
);

	vertex_t stack_mem [STACK_DEPTH];
	vertex_t rd_data_q;

	// Write pushes, register pops
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			stack_mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= stack_mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> sim/walk_scoreboard_pkg.sv
// Scoreboard for the adjacency-matrix depth-first search block.
// Mirrors the edge store and predicts each walk; checks results in order.
// Depends on adm_pkg for sizes, field types and status codes.
`timescale 1ns / 1ps

package walk_scoreboard_pkg;
	import adm_pkg::*;

	typedef struct packed {
		vertex_t    vtx;
		logic [1:0] sts;
		logic       fin;
	} visit_t;

	class walk_scoreboard;
		row_t             edge_rows [MAX_VERTICES];
		logic [CFG_W-1:0] count_reg;
		visit_t           expected_visits [$];
		int               errors;

		function new();
			foreach (edge_rows[i]) edge_rows[i] = '0;
			count_reg = VCOUNT_RESET;
			errors    = 0;
		endfunction

		function void set_count(input logic [CFG_W-1:0] value);
			count_reg = value;
		endfunction

		// Vertices in use, with the register clamped to the legal span
		function int span();
			if (count_reg < VCOUNT_MIN) begin
				return int'(VCOUNT_MIN);
			end
			if (int'(count_reg) > MAX_VERTICES) begin
				return MAX_VERTICES;
			end
			return int'(count_reg);
		endfunction

		function int pending();
			return expected_visits.size();
		endfunction

		function void add_visit(input int v, input logic [1:0] s, input logic f);
			visit_t e;
			e.vtx = vertex_t'(v);
			e.sts = s;
			e.fin = f;
			expected_visits.push_back(e);
		endfunction

		// Update the edge store or predict the visit order of one walk
		function void note_item(input logic op, input vertex_t a, input vertex_t b);
			int      n;
			int      ia;
			int      ib;
			int      sp;
			int      p;
			bit      got;
			row_t    seen;
			vertex_t walk_stack [STACK_DEPTH];
			n  = span();
			ia = int'(a);
			ib = int'(b);
			p  = 0;
			if (op == OP_ADD_EDGE) begin
				if (ia >= 1 && ia <= n && ib >= 1 && ib <= n) begin
					edge_rows[ia-1][ib-1] = 1'b1;
					edge_rows[ib-1][ia-1] = 1'b1;
				end
				return;
			end
			if (ia < 1 || ia > n || ib > n) begin
				add_visit(0, STS_REJECTED, 1'b1);
				return;
			end
			seen          = '0;
			walk_stack[0] = a;
			sp            = 1;
			forever begin
				// Pop until an unvisited vertex turns up
				got = 1'b0;
				while (sp > 0) begin
					sp--;
					p = int'(walk_stack[sp]);
					if (p >= 1 && p <= n && !seen[p-1]) begin
						got = 1'b1;
						break;
					end
				end
				if (!got) begin
					add_visit(0, STS_MISSED, 1'b1);
					return;
				end
				seen[p-1] = 1'b1;
				if (p == ib) begin
					add_visit(p, STS_GOAL, 1'b1);
					return;
				end
				add_visit(p, STS_VISITED, 1'b0);
				// Push unvisited neighbors in ascending order; drop on a full stack
				for (int i = 1; i <= n; i++) begin
					if (edge_rows[p-1][i-1] && !seen[i-1] && sp < STACK_DEPTH) begin
						walk_stack[sp] = vertex_t'(i);
						sp++;
					end
				end
			end
		endfunction

		// Compare one result with the oldest expected visit
		function void check_result(input vertex_t v, input logic [1:0] s, input logic f);
			visit_t e;
			if (expected_visits.size() == 0) begin
				$display("%0t: unexpected result vertex %0d status %0d last %0d, expected none",
					$time, v, s, f);
				errors++;
				return;
			end
			e = expected_visits.pop_front();
			if (v !== e.vtx) begin
				$display("%0t: vertex mismatch: expected %0d, actual %0d", $time, e.vtx, v);
				errors++;
			end
			if (s !== e.sts) begin
				$display("%0t: status mismatch: expected %0d, actual %0d", $time, e.sts, s);
				errors++;
			end
			if (f !== e.fin) begin
				$display("%0t: last mismatch: expected %0d, actual %0d", $time, e.fin, f);
				errors++;
			end
		endfunction
	endclass

endpackage

>>> sim/tb_top.sv
// Top-level testbench for adjacency_matrix_dfs: directed edges and walks, then
// random phases over several vertex counts and idle patterns on both channels.
// Depends on adm_pkg, walk_scoreboard_pkg and the block under test.
`timescale 1ns / 1ps

module tb_top;
	import adm_pkg::*;
	import walk_scoreboard_pkg::*;

	localparam int CYCLE_LIMIT     = 1000000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int TAIL_CYCLES     = 50;
	localparam int ITEMS_PER_PHASE = 34;
	localparam int HOLD_POINT      = 20;
	localparam int NUM_PHASES      = 8;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic               operation = OP_ADD_EDGE;
	vertex_t            vertex_a  = '0;
	vertex_t            vertex_b  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	vertex_t            vertex;
	logic [1:0]         status;
	logic               last;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	walk_scoreboard sb;
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             cycle_count   = 0;

	logic [CFG_W-1:0] phase_counts [NUM_PHASES] = '{5, 2, 0, 1, 12, 17, 31, 16};

	adjacency_matrix_dfs uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.vertex_a  (vertex_a),
		.vertex_b  (vertex_b),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.vertex    (vertex),
		.status    (status),
		.last      (last),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Check accepted results, pick the next ready, watch the cycle budget
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(vertex, status, last);
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Write the vertex count register: setup phase, then access phase
	task automatic write_count(input logic [CFG_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(REG_VERTEX_COUNT) << 2;
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_count(value);
	endtask

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic op, input vertex_t a, input vertex_t b);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct && gap < 20) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		vertex_a  <= a;
		vertex_b  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(op, a, b);
	endtask

	// Drop valid and hold until every expected result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	// Let the block settle after the last result, then change the count
	task automatic reconfigure(input logic [CFG_W-1:0] value);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_count(value);
	endtask

	// Mostly well-formed edges and walks, with some raw noise
	task automatic random_item(input int n, output logic op, output vertex_t a,
		output vertex_t b);
		if ($urandom_range(0, 99) < 15) begin
			op = logic'($urandom_range(0, 1));
			a  = vertex_t'($urandom_range(0, 31));
			b  = vertex_t'($urandom_range(0, 31));
		end else if ($urandom_range(0, 99) < 40) begin
			op = OP_ADD_EDGE;
			a  = vertex_t'($urandom_range(1, n));
			b  = vertex_t'($urandom_range(1, n));
		end else begin
			op = OP_SEARCH;
			a  = vertex_t'($urandom_range(1, n));
			b  = ($urandom_range(0, 99) < 30) ? vertex_t'(0) : vertex_t'($urandom_range(1, n));
		end
	endtask

	initial begin
		int      sent;
		int      n;
		bit      held;
		logic    op;
		vertex_t a;
		vertex_t b;
		sb = new();

		// Reset
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walks at the reset count
		write_count(5'd8);
		send_item(OP_SEARCH, 5'd1, 5'd0);     // empty graph: start only, then not reached
		send_item(OP_SEARCH, 5'd0, 5'd0);     // start zero rejected
		send_item(OP_SEARCH, 5'd9, 5'd0);     // start above count rejected
		send_item(OP_SEARCH, 5'd1, 5'd9);     // goal above count rejected
		send_item(OP_SEARCH, 5'd31, 5'd31);
		send_item(OP_ADD_EDGE, 5'd0, 5'd1);   // bad edges are ignored
		send_item(OP_ADD_EDGE, 5'd1, 5'd9);
		send_item(OP_ADD_EDGE, 5'd31, 5'd31);
		send_item(OP_ADD_EDGE, 5'd3, 5'd3);   // self loop
		send_item(OP_ADD_EDGE, 5'd1, 5'd2);
		send_item(OP_ADD_EDGE, 5'd1, 5'd3);
		send_item(OP_ADD_EDGE, 5'd2, 5'd4);
		send_item(OP_ADD_EDGE, 5'd3, 5'd5);
		send_item(OP_ADD_EDGE, 5'd5, 5'd8);
		send_item(OP_ADD_EDGE, 5'd4, 5'd6);
		send_item(OP_SEARCH, 5'd1, 5'd0);     // whole component
		send_item(OP_SEARCH, 5'd1, 5'd6);     // goal reached
		send_item(OP_SEARCH, 5'd1, 5'd7);     // unreachable goal
		send_item(OP_SEARCH, 5'd2, 5'd2);     // goal is the start
		send_item(OP_SEARCH, 5'd8, 5'd1);
		send_item(OP_SEARCH, 5'd3, 5'd3);

		// Directed walks at the largest count
		reconfigure(5'd16);
		send_item(OP_ADD_EDGE, 5'd16, 5'd15);
		send_item(OP_ADD_EDGE, 5'd8, 5'd16);
		send_item(OP_SEARCH, 5'd16, 5'd0);
		send_item(OP_SEARCH, 5'd1, 5'd16);

		// Random phases over counts and idle patterns
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 63; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 63; end
				default: begin send_idle_pct = 32; recv_idle_pct = 32; end
			endcase
			reconfigure(phase_counts[ph]);
			n    = sb.span();
			sent = 0;
			held = 1'b0;
			while (sent < ITEMS_PER_PHASE) begin
				// Hold off midway until the block has emptied
				if (sent == HOLD_POINT && !held) begin
					drain();
					held = 1'b1;
				end
				random_item(n, op, a, b);
				send_item(op, a, b);
				if (!(op == OP_ADD_EDGE && (a < 1 || a > n || b < 1 || b > n))) begin
					sent++;
				end
			end
		end

		// Wait out the last results and a quiet tail
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
